// ===== design/rkhc_pkg.sv =====
`default_nettype none

package rkhc_pkg;

    // configuration port
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int KEY_WORD_W  = 64;

    // register map
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_WORD_0   = 3'd0,
        REG_KEY_WORD_1   = 3'd1,
        REG_KEY_WORD_2   = 3'd2,
        REG_KEY_WORD_3   = 3'd3,
        REG_KEY_WORD_4   = 3'd4,
        REG_KEY_LENGTH   = 3'd5,
        REG_SEND_HDR_LEN = 3'd6,
        REG_RECV_HDR_LEN = 3'd7
    } t_cfg_reg;

    // field widths
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 16;
    localparam int KEYLEN_W  = 6;
    localparam int HDRLEN_W  = 4;

    // defaults
    localparam int MAX_KEY_BYTES_DEF = 40;
    localparam logic [HDRLEN_W-1:0] SEND_HDR_LEN_RST = 4'd4;
    localparam logic [HDRLEN_W-1:0] RECV_HDR_LEN_RST = 4'd6;

    // op codes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

endpackage

`default_nettype wire

// ===== design/rolling_key_header_cipher_top.sv =====
`default_nettype none

// Rolling-key header cipher, one packet byte per beat. An outgoing byte
// (op = encrypt) becomes (byte xor key[i]) + previous cipher byte; an
// incoming byte (op = decrypt) becomes (byte - previous cipher byte) xor
// key[i]. Send and receive each keep their own key index, wrapping at the
// key length, and their own last cipher byte. Only bytes whose position is
// below the direction's header length, in packets at least that long, are
// ciphered; all others pass through with o_was_ciphered low. A key length
// of zero passes everything, and any write of the key length register
// clears both chains. Rate: one byte per cycle while i_ready is high;
// bytes pass an input register, then a result register. The limit is the
// chain update: the next byte of a direction needs the cipher byte and key
// index this byte leaves, a combinational path through a key byte mux, one
// 8-bit add or subtract and an xor. Configuration is written through a
// plain write port and must only change while no beat is in flight.
module rolling_key_header_cipher_top #(
    parameter int MAX_KEY_BYTES = rkhc_pkg::MAX_KEY_BYTES_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration
    input  wire                                  i_cfg_we,
    input  wire [rkhc_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  wire [rkhc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // input channel
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire                                  i_op,
    input  wire [rkhc_pkg::BYTE_W-1:0]           i_data_byte,
    input  wire [rkhc_pkg::POS_W-1:0]            i_byte_position,
    input  wire [rkhc_pkg::POS_W-1:0]            i_packet_length,
    // result channel
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic [rkhc_pkg::BYTE_W-1:0]          o_out_byte,
    output logic                                 o_was_ciphered
);

    localparam int BW        = rkhc_pkg::BYTE_W;
    localparam int IDX_W     = $clog2(MAX_KEY_BYTES + 1);
    localparam int KEY_WORDS = (MAX_KEY_BYTES + 7) / 8;
    localparam int KEY_BITS  = KEY_WORDS * rkhc_pkg::KEY_WORD_W;
    localparam logic [rkhc_pkg::KEYLEN_W-1:0] MAX_KLEN =
        rkhc_pkg::KEYLEN_W'(MAX_KEY_BYTES);

    // configuration registers
    logic [KEY_BITS-1:0]                r_key;
    logic [rkhc_pkg::KEYLEN_W-1:0]      r_key_len;
    logic [rkhc_pkg::HDRLEN_W-1:0]      r_send_hlen;
    logic [rkhc_pkg::HDRLEN_W-1:0]      r_recv_hlen;

    // chain state
    logic [IDX_W-1:0]                   r_send_idx, n_send_idx;
    logic [IDX_W-1:0]                   r_recv_idx, n_recv_idx;
    logic [BW-1:0]                      r_send_last, n_send_last;
    logic [BW-1:0]                      r_recv_last, n_recv_last;

    // input register
    logic                               r_in_valid;
    logic                               r_in_op;
    logic [BW-1:0]                      r_in_byte;
    logic [rkhc_pkg::POS_W-1:0]         r_in_pos;
    logic [rkhc_pkg::POS_W-1:0]         r_in_plen;

    // result register
    logic                               r_out_valid;
    logic [BW-1:0]                      r_out_byte, n_out_byte;
    logic                               r_out_ciph, n_out_ciph;

    logic                               advance;
    logic                               klen_wr;
    logic [IDX_W-1:0]                   klen;
    logic [rkhc_pkg::HDRLEN_W-1:0]      hlen;
    logic                               cipher_en;
    logic [IDX_W-1:0]                   cur_idx;
    logic [IDX_W-1:0]                   use_idx;
    logic [BW-1:0]                      key_b;
    logic [BW-1:0]                      enc_byte;
    logic [BW-1:0]                      dec_byte;

    // handshakes: result register frees when taken, input stage moves on then
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign o_valid = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_was_ciphered = r_out_ciph;

    assign klen_wr = i_cfg_we &&
                     (i_cfg_index == rkhc_pkg::REG_KEY_LENGTH);

    // effective key length, clamped to storage
    assign klen = (r_key_len > MAX_KLEN) ? IDX_W'(MAX_KEY_BYTES)
                                         : IDX_W'(r_key_len);

    assign hlen = (r_in_op == rkhc_pkg::OP_DECRYPT) ? r_recv_hlen : r_send_hlen;

    assign cipher_en = (klen != '0) &&
                       (r_in_plen >= rkhc_pkg::POS_W'(hlen)) &&
                       (r_in_pos < rkhc_pkg::POS_W'(hlen));

    // stored index is at most klen, and equals it only after the last key byte
    assign cur_idx = (r_in_op == rkhc_pkg::OP_DECRYPT) ? r_recv_idx : r_send_idx;
    assign use_idx = (cur_idx >= klen) ? '0 : cur_idx;

    assign key_b    = r_key[{use_idx, 3'b000} +: BW];
    assign enc_byte = (r_in_byte ^ key_b) + r_send_last;
    assign dec_byte = (r_in_byte - r_recv_last) ^ key_b;

    always_comb begin
        n_send_idx  = r_send_idx;
        n_recv_idx  = r_recv_idx;
        n_send_last = r_send_last;
        n_recv_last = r_recv_last;
        n_out_byte  = r_in_byte;
        n_out_ciph  = 1'b0;
        if (cipher_en) begin
            n_out_ciph = 1'b1;
            if (r_in_op == rkhc_pkg::OP_DECRYPT) begin
                n_out_byte  = dec_byte;
                n_recv_idx  = use_idx + IDX_W'(1);
                n_recv_last = r_in_byte;
            end else begin
                n_out_byte  = enc_byte;
                n_send_idx  = use_idx + IDX_W'(1);
                n_send_last = enc_byte;
            end
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_key_len   <= '0;
            r_send_hlen <= rkhc_pkg::SEND_HDR_LEN_RST;
            r_recv_hlen <= rkhc_pkg::RECV_HDR_LEN_RST;
        end else if (i_cfg_we) begin
            // key words past the stored range are never read
            for (int w = 0; w < KEY_WORDS; w++) begin
                if (i_cfg_index == rkhc_pkg::CFG_INDEX_W'(w)) begin
                    r_key[w*rkhc_pkg::KEY_WORD_W +: rkhc_pkg::KEY_WORD_W] <= i_cfg_data;
                end
            end
            case (rkhc_pkg::t_cfg_reg'(i_cfg_index))
                rkhc_pkg::REG_KEY_LENGTH: begin
                    r_key_len <= i_cfg_data[rkhc_pkg::KEYLEN_W-1:0];
                end
                rkhc_pkg::REG_SEND_HDR_LEN: begin
                    r_send_hlen <= i_cfg_data[rkhc_pkg::HDRLEN_W-1:0];
                end
                rkhc_pkg::REG_RECV_HDR_LEN: begin
                    r_recv_hlen <= i_cfg_data[rkhc_pkg::HDRLEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // chain state; a key length write wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || klen_wr) begin
            r_send_idx  <= '0;
            r_recv_idx  <= '0;
            r_send_last <= '0;
            r_recv_last <= '0;
        end else if (advance) begin
            r_send_idx  <= n_send_idx;
            r_recv_idx  <= n_recv_idx;
            r_send_last <= n_send_last;
            r_recv_last <= n_recv_last;
        end
    end

    // input and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_op   <= i_op;
            r_in_byte <= i_data_byte;
            r_in_pos  <= i_byte_position;
            r_in_plen <= i_packet_length;
        end
        if (advance) begin
            r_out_byte <= n_out_byte;
            r_out_ciph <= n_out_ciph;
        end
    end

    // checks
    a_idx_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_send_idx <= klen) && (r_recv_idx <= klen))
        else $error("key index beyond key length");

    a_klen_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        klen_wr |=> (r_send_idx == '0) && (r_recv_idx == '0) &&
                    (r_send_last == '0) && (r_recv_last == '0))
        else $error("key length write did not clear chains");

    a_pass_unchanged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !cipher_en |=> !r_out_ciph && (r_out_byte == $past(r_in_byte)))
        else $error("pass-through byte altered");

    a_pass_keeps_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !cipher_en && !klen_wr |=>
            $stable(r_send_last) && $stable(r_recv_last) &&
            $stable(r_send_idx) && $stable(r_recv_idx))
        else $error("pass-through byte moved a chain");

    a_one_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && cipher_en && (r_in_op == rkhc_pkg::OP_ENCRYPT) && !klen_wr |=>
            $stable(r_recv_last) && $stable(r_recv_idx))
        else $error("encrypt beat touched receive chain");

endmodule

`default_nettype wire
